### rtl/npt_pkg.sv
// ============================================================================
// npt_pkg: shared types and constants of the nearest point table
// Point and control types, field widths and the control states.
// ============================================================================
`default_nettype none

package npt_pkg;

    localparam int MAX_POINTS = 256;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W + 1;
    localparam int DIST_W      = 52;
    localparam int IDX_FIELD_W = 8;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] tag;
        point_t           pt;
    } feed_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Low bits of a table index as they appear in the result field.
    function automatic logic [IDX_FIELD_W-1:0] idx_field(input logic [IDX_W-1:0] i);
        logic [IDX_W+IDX_FIELD_W-1:0] w;
        w = {{IDX_FIELD_W{1'b0}}, i};
        return w[IDX_FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/npt_cell.sv
// ============================================================================
// npt_cell: one storage cell of the point ring
// Holds one point; loads a new point on add or takes its neighbor's point
// when the ring rotates.
// ============================================================================
`default_nettype none

module npt_cell (
    input  wire                 aclk,
    input  npt_pkg::cell_ctl_t  ctl,
    input  npt_pkg::point_t     load_pt,
    input  npt_pkg::point_t     shift_in,
    output npt_pkg::point_t     q
);
    import npt_pkg::*;

    point_t pt_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            pt_reg <= load_pt;
        end else if (ctl.shift) begin
            pt_reg <= shift_in;
        end
    end

    assign q = pt_reg;

endmodule

`default_nettype wire

### rtl/npt_dist.sv
// ============================================================================
// npt_dist: squared distance pipeline and running minimum
// Difference, square and sum stages feed a compare that keeps the nearest
// point seen since the last start.
// ============================================================================
`default_nettype none

module npt_dist (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           start,
    input  npt_pkg::feed_t                feed,
    input  npt_pkg::point_t               query,
    output logic                          busy,
    output logic [npt_pkg::IDX_W-1:0]     best_idx,
    output logic [npt_pkg::DIST_W-1:0]    best_dist
);
    import npt_pkg::*;

    logic                     v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]         t1_reg, t2_reg, t3_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]          sx_reg, sy_reg, sz_reg;
    logic [DIST_W-1:0]        sum_reg;
    logic                     have_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [DIST_W-1:0]        best_dist_reg;

    logic signed [2*DIFF_W-1:0] px, py, pz;
    logic [DIST_W-1:0]          sum_next;

    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;
    assign sum_next = DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            have_reg <= 1'b0;
        end else begin
            v1_reg <= feed.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (start) begin
                have_reg <= 1'b0;
            end else if (v3_reg) begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        t1_reg <= feed.tag;
        dx_reg <= DIFF_W'(feed.pt.x) - DIFF_W'(query.x);
        dy_reg <= DIFF_W'(feed.pt.y) - DIFF_W'(query.y);
        dz_reg <= DIFF_W'(feed.pt.z) - DIFF_W'(query.z);
        t2_reg <= t1_reg;
        sx_reg <= px[SQ_W-1:0];
        sy_reg <= py[SQ_W-1:0];
        sz_reg <= pz[SQ_W-1:0];
        t3_reg <= t2_reg;
        sum_reg <= sum_next;
        // Strict less-than so that a tie keeps the earlier index.
        if (v3_reg && (!have_reg || sum_reg < best_dist_reg)) begin
            best_idx_reg  <= t3_reg;
            best_dist_reg <= sum_reg;
        end
    end

    assign busy      = v1_reg | v2_reg | v3_reg;
    assign best_idx  = best_idx_reg;
    assign best_dist = best_dist_reg;

endmodule

`default_nettype wire

### rtl/nearest_point_table_3d.sv
// ============================================================================
// nearest_point_table_3d: point table with linear nearest neighbor search
// Adds append a 3D point; queries scan a rotating ring of point cells.
// ============================================================================
//  channel | direction | tdata                         | tuser
//  s_      | in        | pos_x, pos_y, pos_z           | operation
//  m_      | out       | point_index, best_distance    | table_full, table_empty
//
// An add, or a query on an empty table, gives its word in the cycle after accept.
// A query rotates the cell ring through all MAX_POINTS cells, one a cycle, and
// drains a three stage distance pipeline before its word is given.
// Reset empties the table; stored points are kept in cells without reset.
// A stalled result word holds; new words are taken only once it has left.
// ============================================================================
`default_nettype none

module nearest_point_table_3d (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // pos_x [23:0], pos_y [47:24], pos_z [71:48]
    input  wire [npt_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation [0]
    input  wire [npt_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // point_index [7:0], best_distance [59:8], zero [63:60]
    output logic [npt_pkg::M_TDATA_W-1:0]   m_tdata,
    // table_full [0], table_empty [1]
    output logic [npt_pkg::M_TUSER_W-1:0]   m_tuser
);
    import npt_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    point_t            query_reg;

    logic                   out_valid_reg;
    logic [IDX_FIELD_W-1:0] out_idx_reg;
    logic                   out_full_reg;
    logic                   out_empty_reg;
    logic [DIST_W-1:0]      out_dist_reg;

    logic    out_free, accept, is_add, add_ok, imm_result, scan_last;
    logic    dist_busy, dist_start;
    feed_t   feed;
    point_t  in_pt;
    point_t  ring_q [MAX_POINTS];
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_dist;

    assign in_pt.x = s_tdata[COORD_W-1:0];
    assign in_pt.y = s_tdata[2*COORD_W-1:COORD_W];
    assign in_pt.z = s_tdata[3*COORD_W-1:2*COORD_W];

    assign out_free  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_add    = (s_tuser[0] == OP_ADD);
    assign add_ok    = accept && is_add && (count_reg < CNT_W'(MAX_POINTS));
    assign imm_result = accept && (is_add || count_reg == '0);
    assign scan_last = (scan_idx_reg == IDX_W'(MAX_POINTS - 1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !is_add && count_reg != '0) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!dist_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the control.
    always_comb begin
        s_tready   = 1'b0;
        dist_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = out_free;
                dist_start = 1'b1;
            end
            ST_SCAN, ST_DRAIN, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign feed.valid = (state_reg == ST_SCAN) && (CNT_W'(scan_idx_reg) < count_reg);
    assign feed.tag   = scan_idx_reg;
    assign feed.pt    = ring_q[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (add_ok) begin
                count_reg <= count_reg + 1'b1;
            end
            if (imm_result || (state_reg == ST_DONE && out_free)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            query_reg    <= in_pt;
            scan_idx_reg <= '0;
        end else if (state_reg == ST_SCAN) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (imm_result) begin
            out_idx_reg   <= add_ok ? idx_field(count_reg[IDX_W-1:0]) : '0;
            out_full_reg  <= is_add && !add_ok;
            out_empty_reg <= !is_add;
            out_dist_reg  <= '0;
        end else if (state_reg == ST_DONE && out_free) begin
            out_idx_reg   <= idx_field(best_idx);
            out_full_reg  <= 1'b0;
            out_empty_reg <= 1'b0;
            out_dist_reg  <= best_dist;
        end
    end

    // Ring of point cells: on each scan cycle every cell takes its upper
    // neighbor's point, so cell zero shows the points in index order and
    // the ring is back in place once it has turned through all MAX_POINTS cells.
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        cell_ctl_t ctl;
        assign ctl.load  = add_ok && (count_reg == CNT_W'(i));
        assign ctl.shift = (state_reg == ST_SCAN);
        npt_cell u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .load_pt  (in_pt),
            .shift_in (ring_q[(i + 1) % MAX_POINTS]),
            .q        (ring_q[i])
        );
    end

    npt_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (dist_start),
        .feed      (feed),
        .query     (query_reg),
        .busy      (dist_busy),
        .best_idx  (best_idx),
        .best_dist (best_dist)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - DIST_W - IDX_FIELD_W){1'b0}}, out_dist_reg, out_idx_reg};
    assign m_tuser  = {out_empty_reg, out_full_reg};

endmodule

`default_nettype wire

### rtl/npt_checker.sv
// ============================================================================
// npt_checker: port level checks of the nearest point table
// Watches the result channel for stalls and for consistent flag words.
// ============================================================================
`default_nettype none

module npt_checker (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    input  wire                             s_tready,
    input  wire                             m_tvalid,
    input  wire                             m_tready,
    input  wire [npt_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire [npt_pkg::M_TUSER_W-1:0]    m_tuser
);
    import npt_pkg::*;

    // A stalled result word stays in place.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A dropped add and an empty query never share one word.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("full and empty flagged together");

    // Flagged words carry index zero and no distance.
    a_flag_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |->
            m_tdata[DIST_W+IDX_FIELD_W-1:0] == '0)
        else $error("flagged word carries data");

    // No new word is taken while a result word is stalled.
    a_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
        else $error("word accepted while result stalled");

endmodule

bind nearest_point_table_3d npt_checker u_npt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
